// ----- design/dtfol_pkg.sv -----
// shared widths, configuration register codes and control structs of the dead-time lag plant
package dtfol_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int DELAY_W    = 10;
    localparam int RATIO_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_GAIN      = 2'd2;

    localparam logic [DELAY_W-1:0]       DELAY_RESET = 10'd39;
    localparam logic [RATIO_W-1:0]       RATIO_RESET = 16'd218;
    localparam logic signed [GAIN_W-1:0] GAIN_RESET  = 16'sd4096;

    typedef struct packed {
        logic start;
        logic out_free;
    } t_core_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

endpackage

// ----- design/dtfol_delay_line.sv -----
// dead-time ring buffer with fill tracking so unwritten cells read zero
module dtfol_delay_line
    import dtfol_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic signed [SAMPLE_W-1:0] i_drive,
    input  logic [DELAY_W-1:0]         i_delay,
    output logic signed [SAMPLE_W-1:0] o_delayed
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (AW > DELAY_W) ? AW : DELAY_W;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_q;
    logic [AW-1:0]       r_wp;
    logic                r_full;
    logic                r_hit;
    logic                r_bypass;
    logic signed [SAMPLE_W-1:0] r_drive;

    logic [CW-1:0] dly_ext;
    logic [AW-1:0] dly_sat;
    logic [AW:0]   rd_wrap;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wp_next;
    logic          bypass;

    assign bypass  = (i_delay == '0);
    assign dly_ext = CW'(i_delay);
    assign dly_sat = (dly_ext > CW'(DEPTH - 1)) ? AW'(DEPTH - 1) : AW'(dly_ext);
    assign rd_wrap = {1'b0, r_wp} + (AW + 1)'(DEPTH) - {1'b0, dly_sat};
    assign rd_addr = (r_wp >= dly_sat) ? (r_wp - dly_sat) : AW'(rd_wrap);
    assign wp_next = (r_wp == AW'(DEPTH - 1)) ? '0 : (r_wp + AW'(1));

    always_ff @(posedge i_clk) begin
        if (i_push && !bypass) begin
            r_mem[r_wp] <= i_drive;
            r_q         <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_drive <= i_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_full   <= 1'b0;
            r_hit    <= 1'b0;
            r_bypass <= 1'b0;
        end else if (i_push) begin
            r_bypass <= bypass;
            if (!bypass) begin
                // cells below the write pointer were filled before the first wrap
                r_hit <= r_full || (rd_addr < r_wp);
                r_wp  <= wp_next;
                if (r_wp == AW'(DEPTH - 1)) begin
                    r_full <= 1'b1;
                end
            end
        end
    end

    assign o_delayed = r_bypass ? r_drive : (r_hit ? $signed(r_q) : '0);

endmodule

// ----- design/dtfol_rk4_core.sv -----
// sequenced rk4 lag step around one shared multiplier, with digit-wise divide by three
module dtfol_rk4_core
    import dtfol_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_core_ctl                  i_ctl,
    input  logic [RATIO_W-1:0]         i_step_ratio,
    input  logic signed [GAIN_W-1:0]   i_lag_gain,
    input  logic signed [SAMPLE_W-1:0] i_delayed,
    output t_core_stat                 o_stat,
    output logic signed [SAMPLE_W-1:0] o_plant_out,
    output logic signed [SAMPLE_W-1:0] o_delayed_drive
);

    localparam int ERR_W  = 34;
    localparam int K_W    = 35;
    localparam int SUM_W  = 38;
    localparam int MB_W   = 17;
    localparam int PROD_W = 55;
    localparam int QUO_W  = 48;
    localparam int DIG_W  = 16;
    localparam int V_W    = 18;
    localparam int VM_W   = 36;
    localparam int Y_W    = 45;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_MULG  = 3'd4;
    localparam logic [2:0] S_SCALE = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic signed [PROD_W-1:0] K_ROUND   = 55'sd32768;
    localparam logic signed [PROD_W-1:0] DIV_ROUND = 55'sd12288;
    // bias keeps the dividend positive: 3 * 2^41, removed again as 2^41
    localparam logic [QUO_W-1:0]         DIV_BIAS  = 48'd3 << 41;
    localparam logic signed [Y_W-1:0]    QUO_OFS   = 45'sd1 <<< 41;
    localparam logic [V_W-1:0]           DIV3_RECIP = 18'd174763;
    localparam logic signed [Y_W-1:0]    SAT_MAX   = 45'sd2147483647;
    localparam logic signed [Y_W-1:0]    SAT_MIN   = -45'sd2147483648;

    logic [2:0]                 r_state;
    logic [1:0]                 r_cnt;
    logic signed [SAMPLE_W-1:0] r_lag;
    logic signed [SAMPLE_W-1:0] r_u;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [PROD_W-1:0]   r_prod;
    logic [QUO_W-1:0]           r_quo;
    logic [1:0]                 r_rem;

    logic signed [SUM_W-1:0]    mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]   mul_res;
    logic signed [PROD_W-1:0]   k_round;
    logic signed [K_W-1:0]      k;
    logic signed [K_W-1:0]      k_half;
    logic signed [K_W-1:0]      k_base;
    logic signed [SUM_W-1:0]    k_add;
    logic signed [ERR_W-1:0]    err_next;
    logic signed [ERR_W-1:0]    err_load;
    logic signed [PROD_W-1:0]   x_full;
    logic [QUO_W-1:0]           quo_load;
    logic [V_W-1:0]             div_v;
    logic [VM_W-1:0]            div_vm;
    logic [DIG_W-1:0]           div_q;
    logic [V_W-1:0]             div_r;
    logic signed [Y_W-1:0]      y_sum;
    logic signed [SAMPLE_W-1:0] y_new;
    logic                       finish;

    // shared multiplier: ratio times error for the four stages, then gain times sum
    assign mul_a   = (r_state == S_MULG) ? r_sum : SUM_W'(r_err);
    assign mul_b   = (r_state == S_MULG) ? MB_W'(i_lag_gain) : $signed({1'b0, i_step_ratio});
    assign mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign k_round  = (r_prod + K_ROUND) >>> 16;
    assign k        = K_W'(k_round);
    assign k_half   = (k + K_W'(1)) >>> 1;
    assign k_base   = (r_cnt == 2'd2) ? k : k_half;
    assign k_add    = (r_cnt == 2'd1 || r_cnt == 2'd2) ? (SUM_W'(k) <<< 1) : SUM_W'(k);
    assign err_next = ERR_W'(SUM_W'(r_u) - SUM_W'(r_lag) - SUM_W'(k_base));
    assign err_load = ERR_W'(i_delayed) - ERR_W'(r_lag);

    assign x_full   = (r_prod + DIV_ROUND) >>> 13;
    assign quo_load = QUO_W'(x_full) + DIV_BIAS;

    // one 16-bit digit of the divide by three per step
    assign div_v  = {r_rem, r_quo[QUO_W-1 -: DIG_W]};
    assign div_vm = VM_W'(div_v) * VM_W'(DIV3_RECIP);
    assign div_q  = div_vm[34:19];
    assign div_r  = div_v - (V_W'(div_q) * V_W'(3));

    assign y_sum = Y_W'(r_lag) + $signed({2'b00, r_quo[42:0]}) - QUO_OFS;

    always_comb begin
        if (y_sum > SAT_MAX) begin
            y_new = SAMPLE_W'(SAT_MAX);
        end else if (y_sum < SAT_MIN) begin
            y_new = SAMPLE_W'(SAT_MIN);
        end else begin
            y_new = SAMPLE_W'(y_sum);
        end
    end

    assign finish = (r_state == S_DONE) && i_ctl.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_lag   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_MULG;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MULG: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd2) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (finish) begin
                        r_lag   <= y_new;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                r_u   <= i_delayed;
                r_err <= err_load;
                r_sum <= '0;
            end
            S_MUL, S_MULG: begin
                r_prod <= mul_res;
            end
            S_ACC: begin
                r_sum <= r_sum + k_add;
                r_err <= err_next;
            end
            S_SCALE: begin
                r_quo <= quo_load;
                r_rem <= '0;
            end
            S_DIV: begin
                r_quo <= {r_quo[QUO_W-DIG_W-1:0], div_q};
                r_rem <= div_r[1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.done     = finish;
    assign o_plant_out     = y_new;
    assign o_delayed_drive = r_u;

`ifndef SYNTHESIS
    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_ctl.start) |=> (r_state == S_LOAD))
        else $error("start did not enter load");

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != 2'd3))
        else $error("divide step count overran");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_DONE) |-> (r_rem != 2'd3))
        else $error("divide by three remainder out of range");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_quo[QUO_W-1:43] == '0))
        else $error("scaled quotient out of range");

    a_lag_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE) |=> $stable(r_lag))
        else $error("lag level changed outside completion");
`endif

endmodule

// ----- design/dead_time_first_order_lag_plant.sv -----
// One drive sample per transfer goes through a dead-time ring buffer (delay 0 passes it straight
// through; cells never written read zero through fill tracking, so there is no clearing pass
// after reset) and then advances a first-order lag by one fixed-point Runge-Kutta step. The core
// steps through its states in order: the four dependent stages each take a multiply state and an
// accumulate state on the one shared multiplier, followed by the gain multiply, a rounding state,
// a three-digit divide by three and a saturation state. The result waits in an output register,
// and a new input is taken while it waits; the core holds in its done state only while that
// register is still full and not being read.
module dead_time_first_order_lag_plant
    import dtfol_pkg::*;
#(
    parameter int DELAY_DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [SAMPLE_W-1:0]   i_drive_sample,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [SAMPLE_W-1:0]   o_plant_out,
    output logic signed [SAMPLE_W-1:0]   o_delayed_drive
);

    logic [DELAY_W-1:0]         r_delay_samples;
    logic [RATIO_W-1:0]         r_step_ratio;
    logic signed [GAIN_W-1:0]   r_lag_gain;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_plant_out;
    logic signed [SAMPLE_W-1:0] r_delayed_drive;

    t_core_ctl                  core_ctl;
    t_core_stat                 core_stat;
    logic                       in_xfer;
    logic signed [SAMPLE_W-1:0] delayed;
    logic signed [SAMPLE_W-1:0] core_plant_out;
    logic signed [SAMPLE_W-1:0] core_delayed_drive;

    assign o_in_ready        = core_stat.idle;
    assign in_xfer           = i_in_valid && core_stat.idle;
    assign core_ctl.start    = in_xfer;
    assign core_ctl.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_samples <= DELAY_RESET;
            r_step_ratio    <= RATIO_RESET;
            r_lag_gain      <= GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DELAY_SAMPLES: r_delay_samples <= i_cfg_wdata[DELAY_W-1:0];
                CFG_STEP_RATIO:    r_step_ratio    <= i_cfg_wdata[RATIO_W-1:0];
                CFG_LAG_GAIN:      r_lag_gain      <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    dtfol_delay_line #(
        .DEPTH (DELAY_DEPTH)
    ) u_delay (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (in_xfer),
        .i_drive   (i_drive_sample),
        .i_delay   (r_delay_samples),
        .o_delayed (delayed)
    );

    dtfol_rk4_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (core_ctl),
        .i_step_ratio    (r_step_ratio),
        .i_lag_gain      (r_lag_gain),
        .i_delayed       (delayed),
        .o_stat          (core_stat),
        .o_plant_out     (core_plant_out),
        .o_delayed_drive (core_delayed_drive)
    );

    // output register, loaded when the core completes into a free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_stat.done) begin
            r_plant_out     <= core_plant_out;
            r_delayed_drive <= core_delayed_drive;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_plant_out     = r_plant_out;
    assign o_delayed_drive = r_delayed_drive;

endmodule

// ----- bench/tb.sv -----
// self-checking testbench for the dead-time first-order lag plant
`timescale 1ns / 100ps

module tb;
    import dtfol_pkg::*;

    localparam int LINE_DEPTH  = 1024;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 24;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] plant_out;
        logic signed [SAMPLE_W-1:0] delayed_drive;
    } t_plant_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = CFG_DELAY_SAMPLES;
    logic [CFG_DATA_W-1:0]      i_cfg_wdata = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_drive_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_plant_out;
    logic signed [SAMPLE_W-1:0] o_delayed_drive;

    // shadow copy of the plant state and registers
    logic signed [SAMPLE_W-1:0] dead_time_line [LINE_DEPTH];
    int                         line_wr_ptr = 0;
    logic signed [SAMPLE_W-1:0] lag_state = '0;
    logic [DELAY_W-1:0]         cur_delay = DELAY_RESET;
    logic [RATIO_W-1:0]         cur_ratio = RATIO_RESET;
    logic signed [GAIN_W-1:0]   cur_gain = GAIN_RESET;

    t_plant_result awaited_results[$];
    int  fail_count = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  out_stall_left = 0;
    bit  in_gaps_on = 1'b0;
    bit  out_stalls_on = 1'b0;

    dead_time_first_order_lag_plant #(
        .DELAY_DEPTH (LINE_DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_drive_sample  (i_drive_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_plant_out     (o_plant_out),
        .o_delayed_drive (o_delayed_drive)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q -= 1;
        return q;
    endfunction

    function automatic longint round_div(longint a, longint b);
        return floor_div(a + b / 2, b);
    endfunction

    function automatic longint ratio_scale(longint err);
        return round_div(err * longint'(cur_ratio), 65536);
    endfunction

    // one dead-time shift plus one RK4 step of the lag
    function automatic t_plant_result predict_lag_step(logic signed [SAMPLE_W-1:0] drive);
        t_plant_result res;
        int     dly;
        int     rd_ptr;
        longint u, y, k1, k2, k3, k4, sum, d, lvl;
        if (cur_delay == 0) begin
            res.delayed_drive = drive;
        end else begin
            dly = (int'(cur_delay) > LINE_DEPTH - 1) ? LINE_DEPTH - 1 : int'(cur_delay);
            rd_ptr = (line_wr_ptr + LINE_DEPTH - dly) % LINE_DEPTH;
            res.delayed_drive = dead_time_line[rd_ptr];
            dead_time_line[line_wr_ptr] = drive;
            line_wr_ptr = (line_wr_ptr + 1) % LINE_DEPTH;
        end
        u   = longint'(res.delayed_drive);
        y   = longint'(lag_state);
        k1  = ratio_scale(u - y);
        k2  = ratio_scale(u - (y + round_div(k1, 2)));
        k3  = ratio_scale(u - (y + round_div(k2, 2)));
        k4  = ratio_scale(u - (y + k3));
        sum = k1 + 2 * k2 + 2 * k3 + k4;
        d   = round_div(sum * longint'(cur_gain), 6 * 4096);
        lvl = y + d;
        if (lvl > longint'(32'sh7fffffff))
            lvl = longint'(32'sh7fffffff);
        else if (lvl < -longint'(64'sd2147483648))
            lvl = -longint'(64'sd2147483648);
        lag_state = lvl[SAMPLE_W-1:0];
        res.plant_out = lag_state;
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic note_mismatch(string field, logic [SAMPLE_W-1:0] want,
                                 logic [SAMPLE_W-1:0] got);
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endtask

    // result side: random stalls, every transfer checked against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_plant_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result with nothing awaited: %h %h",
                                 o_plant_out, o_delayed_drive);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_plant_out !== want.plant_out)
                        note_mismatch("plant_out", want.plant_out, o_plant_out);
                    if (o_delayed_drive !== want.delayed_drive)
                        note_mismatch("delayed_drive", want.delayed_drive, o_delayed_drive);
                end
            end
            if (out_stall_left > 0) begin
                i_out_ready <= 1'b0;
                out_stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                out_stall_left = pick_gap(out_stalls_on);
            end
        end
    end

    task automatic send_drive(logic signed [SAMPLE_W-1:0] sample);
        int gap;
        gap = pick_gap(in_gaps_on);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_drive_sample <= sample;
        do @(posedge i_clk); while (!o_in_ready);
        awaited_results.push_back(predict_lag_step(sample));
    endtask

    // stop sending and wait until every result is back and the core is idle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_plant(logic [DELAY_W-1:0] dly, logic [RATIO_W-1:0] ratio,
                             logic signed [GAIN_W-1:0] gain);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_DELAY_SAMPLES;
        i_cfg_wdata <= CFG_DATA_W'(dly);
        @(posedge i_clk);
        i_cfg_index <= CFG_STEP_RATIO;
        i_cfg_wdata <= ratio;
        @(posedge i_clk);
        i_cfg_index <= CFG_LAG_GAIN;
        i_cfg_wdata <= gain;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_delay = dly;
        cur_ratio = ratio;
        cur_gain  = gain;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_drive();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom;
        if (r < 8)
            return int'($urandom_range(0, 1048575)) - 524288;
        if (r == 8)
            return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        return int'($urandom_range(0, 2)) - 1;
    endfunction

    // reset registers, cells never written read back as zero
    task automatic test_reset_defaults();
        send_drive(32'sh00000000);
        send_drive(32'sh7fffffff);
        send_drive(32'sh80000000);
        send_drive(32'sh00000001);
        send_drive(-32'sd1);
    endtask

    // pass-through with the largest ratio and gain drives the lag into saturation
    task automatic test_pass_through_saturation();
        set_plant('0, 16'hffff, 16'sh7fff);
        repeat (4) send_drive(32'sh7fffffff);
        repeat (4) send_drive(32'sh80000000);
    endtask

    // shortest and longest dead time, negative and zero-rate lag
    task automatic test_delay_extremes();
        set_plant(10'd1, 16'h8000, 16'sh8000);
        send_drive(32'sh12345678);
        send_drive(32'shedcba987);
        send_drive(32'sh00010000);
        send_drive(32'sh7fffffff);
        set_plant(10'd1023, 16'h0000, -16'sd1);
        send_drive(32'sh55aa55aa);
        send_drive(32'shaa55aa55);
        send_drive(32'sh00000000);
    endtask

    task automatic test_random_stream();
        logic [DELAY_W-1:0]       dly;
        logic [RATIO_W-1:0]       ratio;
        logic signed [GAIN_W-1:0] gain;
        for (int phase = 0; phase < 10; phase++) begin
            case ($urandom_range(0, 5))
                0: dly = '0;
                1: dly = 10'd1;
                2: dly = 10'd1023;
                3: dly = DELAY_W'($urandom);
                default: dly = DELAY_W'($urandom_range(2, 80));
            endcase
            case ($urandom_range(0, 3))
                0: ratio = 16'hffff;
                1: ratio = '0;
                default: ratio = RATIO_W'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: gain = 16'sh7fff;
                1: gain = 16'sh8000;
                2: gain = '0;
                default: gain = GAIN_W'($urandom);
            endcase
            set_plant(dly, ratio, gain);
            in_gaps_on    = (phase % 4) != 1;
            out_stalls_on = (phase % 3) != 2;
            for (int k = 0; k < 95; k++) begin
                // let the pipeline run dry mid-stream now and then
                if (k == 40 && phase % 3 == 0)
                    drain_results();
                send_drive(random_drive());
            end
        end
    endtask

    initial begin
        for (int i = 0; i < LINE_DEPTH; i++)
            dead_time_line[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_pass_through_saturation();
        test_delay_extremes();
        test_random_stream();
        drain_results();
        fail_count += awaited_results.size();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- dead_time_first_order_lag_plant.f -----
design/dtfol_pkg.sv
design/dtfol_delay_line.sv
design/dtfol_rk4_core.sv
design/dead_time_first_order_lag_plant.sv
bench/tb.sv
